/* design/lqam_pkg.sv */
// ----------------------------------------------------------------------------
// lqam_pkg
// Shared types and constants for the link quality alarm monitor.
// ----------------------------------------------------------------------------
package lqam_pkg;

    // Default parameter values.
    localparam int RTT_WIDTH_DEF     = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int SPAN_WIDTH_DEF    = 12;

    // Fixed field widths.
    localparam int LEVEL_W   = 14;
    localparam int THRESH_W  = 16;
    localparam int TIME_W    = 32;
    localparam int NUM_ALARM = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // Loss level scale: hundredths of a percent.
    localparam int LOSS_SCALE = 10000;

    // Register indexes.
    localparam logic [2:0] REG_SPAN         = 3'd0;
    localparam logic [2:0] REG_LOSS_HIGH    = 3'd1;
    localparam logic [2:0] REG_LOSS_LOW     = 3'd2;
    localparam logic [2:0] REG_LATENCY_HIGH = 3'd3;
    localparam logic [2:0] REG_LATENCY_LOW  = 3'd4;
    localparam logic [2:0] REG_JITTER_HIGH  = 3'd5;
    localparam logic [2:0] REG_JITTER_LOW   = 3'd6;
    localparam logic [2:0] REG_INERTIA      = 3'd7;

    // Register reset values.
    localparam int SPAN_RST         = 200;
    localparam int LOSS_HIGH_RST    = 100;
    localparam int LOSS_LOW_RST     = 50;
    localparam int LATENCY_HIGH_RST = 200;
    localparam int LATENCY_LOW_RST  = 150;
    localparam int JITTER_HIGH_RST  = 0;
    localparam int JITTER_LOW_RST   = 0;
    localparam int INERTIA_RST      = 30;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_DIV   = 5'b00100,
        S_APPLY = 5'b01000,
        S_EVAL  = 5'b10000
    } state_t;

    // Divider operations, in the order they run for each word.
    typedef enum logic [2:0] {
        OP_DEC_LAT  = 3'd0,
        OP_DEC_LOSS = 3'd1,
        OP_DEC_JIT  = 3'd2,
        OP_LVL_LOSS = 3'd3,
        OP_LVL_LAT  = 3'd4,
        OP_LVL_JIT  = 3'd5
    } op_t;

endpackage

/* design/link_quality_alarm_monitor.sv */
// ----------------------------------------------------------------------------
// link_quality_alarm_monitor
// Windowed loss, latency and jitter tracking with hysteretic alarms.
// ----------------------------------------------------------------------------
// Each input word is one probe result. A single restoring divider, one
// quotient bit per cycle, is shared by up to six divisions per word: three
// window decays and three level computations, run in order by a small
// sequencer. A division passes through S_SETUP, DW steps in S_DIV and the
// write-back in S_APPLY; a skipped division passes through S_SETUP only.
// in_stall is high while a word is in the sequencer. The result word is held
// in an output register, so the next word is accepted while a result waits.
module link_quality_alarm_monitor #(
    parameter int RTT_WIDTH     = lqam_pkg::RTT_WIDTH_DEF,
    parameter int FRACTION_BITS = lqam_pkg::FRACTION_BITS_DEF,
    parameter int SPAN_WIDTH    = lqam_pkg::SPAN_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lqam_pkg::ADDR_W-1:0]   paddr,
    input  logic [lqam_pkg::DATA_W-1:0]   pwdata,
    output logic [lqam_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [RTT_WIDTH-1:0]          round_trip_ms,
    input  logic [lqam_pkg::TIME_W-1:0]   now_seconds,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          loss_alarm,
    output logic                          latency_alarm,
    output logic                          jitter_alarm,
    output logic [2:0]                    raised_mask,
    output logic [2:0]                    cleared_mask,
    output logic                          is_operational,
    output logic [lqam_pkg::LEVEL_W-1:0]  loss_level,
    output logic [15:0]                   latency_average,
    output logic [15:0]                   jitter_average
);
    import lqam_pkg::*;

    localparam int CW  = SPAN_WIDTH + 1;
    localparam int LSW = CW + FRACTION_BITS;
    localparam int SW  = RTT_WIDTH + FRACTION_BITS + CW;
    localparam int LPW = LSW + LEVEL_W;
    localparam int DW  = (SW > LPW) ? SW : LPW;
    localparam int DVW = CW + FRACTION_BITS;
    localparam int KW  = $clog2(DW);

    // Configuration registers.
    logic [SPAN_WIDTH-1:0] span_reg;
    logic [LEVEL_W-1:0]    loss_high_reg, loss_low_reg;
    logic [THRESH_W-1:0]   lat_high_reg, lat_low_reg;
    logic [THRESH_W-1:0]   jit_high_reg, jit_low_reg;
    logic [THRESH_W-1:0]   inertia_reg;

    // Window state.
    logic [LSW-1:0]        loss_sum_reg;
    logic [SW-1:0]         lat_sum_reg, jit_sum_reg;
    logic [CW-1:0]         loss_cnt_reg, lat_cnt_reg, jit_cnt_reg;
    logic [RTT_WIDTH-1:0]  last_rtt_reg;
    logic                  window_full_reg;
    logic [2:0]            flags_reg;
    logic [TIME_W-1:0]     raise_time_reg [NUM_ALARM];
    logic [TIME_W-1:0]     now_reg;

    // Levels of the current word.
    logic [LEVEL_W-1:0]    lvl_loss_reg;
    logic [15:0]           lvl_lat_reg, lvl_jit_reg;

    // Sequencer and divider.
    state_t                state_reg;
    op_t                   op_reg;
    logic [DVW:0]          rem_reg;
    logic [DW-1:0]         quo_reg;
    logic [DVW-1:0]        div_reg;
    logic [KW-1:0]         cnt_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [2:0]            out_flags_reg, out_raised_reg, out_cleared_reg;
    logic                  out_oper_reg;
    logic [LEVEL_W-1:0]    out_loss_reg;
    logic [15:0]           out_lat_reg, out_jit_reg;

    logic                  cfg_write;
    logic                  accept;
    logic                  out_fire;
    logic [RTT_WIDTH-1:0]  diff;
    logic [CW-1:0]         loss_cnt_inc;

    assign cfg_write = psel && penable && pwrite;
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign pready    = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);

    // The finished word moves into the output register once it is free.
    assign out_fire  = (state_reg == S_EVAL) && (!out_valid_reg || !out_stall);

    // Register read-back.
    always_comb
    begin
        unique case (paddr[4:2])
            REG_SPAN:         prdata = DATA_W'(span_reg);
            REG_LOSS_HIGH:    prdata = DATA_W'(loss_high_reg);
            REG_LOSS_LOW:     prdata = DATA_W'(loss_low_reg);
            REG_LATENCY_HIGH: prdata = DATA_W'(lat_high_reg);
            REG_LATENCY_LOW:  prdata = DATA_W'(lat_low_reg);
            REG_JITTER_HIGH:  prdata = DATA_W'(jit_high_reg);
            REG_JITTER_LOW:   prdata = DATA_W'(jit_low_reg);
            REG_INERTIA:      prdata = DATA_W'(inertia_reg);
            default:          prdata = '0;
        endcase
    end

    // Jitter sample: zero until a first good probe has been seen.
    always_comb
    begin
        if (last_rtt_reg == '0)
            diff = '0;
        else if (last_rtt_reg > round_trip_ms)
            diff = last_rtt_reg - round_trip_ms;
        else
            diff = round_trip_ms - last_rtt_reg;
    end

    assign loss_cnt_inc = loss_cnt_reg + CW'(1);

    // Divider setup for the current operation.
    logic           op_go;
    logic [DW-1:0]  op_dividend;
    logic [DVW-1:0] op_divisor;
    logic [LPW-1:0] loss_product;

    assign loss_product = LPW'(loss_sum_reg) * LPW'(LOSS_SCALE);

    always_comb
    begin
        unique case (op_reg)
            OP_DEC_LAT:
            begin
                op_go       = (lat_cnt_reg > CW'(span_reg));
                op_dividend = DW'(lat_sum_reg);
                op_divisor  = DVW'(lat_cnt_reg);
            end
            OP_DEC_LOSS:
            begin
                op_go       = (loss_cnt_reg > CW'(span_reg));
                op_dividend = DW'(loss_sum_reg);
                op_divisor  = DVW'(loss_cnt_reg);
            end
            OP_DEC_JIT:
            begin
                op_go       = (jit_cnt_reg > CW'(span_reg));
                op_dividend = DW'(jit_sum_reg);
                op_divisor  = DVW'(jit_cnt_reg);
            end
            OP_LVL_LOSS:
            begin
                op_go       = (loss_cnt_reg != '0);
                op_dividend = DW'(loss_product);
                op_divisor  = DVW'(loss_cnt_reg) << FRACTION_BITS;
            end
            OP_LVL_LAT:
            begin
                op_go       = (lat_cnt_reg != '0);
                op_dividend = DW'(lat_sum_reg);
                op_divisor  = DVW'(lat_cnt_reg) << FRACTION_BITS;
            end
            OP_LVL_JIT:
            begin
                op_go       = (jit_cnt_reg != '0);
                op_dividend = DW'(jit_sum_reg);
                op_divisor  = DVW'(jit_cnt_reg) << FRACTION_BITS;
            end
            default:
            begin
                op_go       = 1'b0;
                op_dividend = '0;
                op_divisor  = '0;
            end
        endcase
    end

    // One restoring divider step.
    logic [DVW:0] trial;
    logic         trial_ok;

    assign trial    = {rem_reg[DVW-1:0], quo_reg[DW-1]};
    assign trial_ok = (trial >= {1'b0, div_reg});

    // Alarm evaluation.
    logic [15:0]       ev_level [NUM_ALARM];
    logic [15:0]       ev_high  [NUM_ALARM];
    logic [15:0]       ev_low   [NUM_ALARM];
    logic [2:0]        ev_valid;
    logic [2:0]        flags_next, raised_next, cleared_next;
    logic [TIME_W-1:0] elapsed [NUM_ALARM];

    assign ev_level[0] = 16'(lvl_loss_reg);
    assign ev_level[1] = lvl_lat_reg;
    assign ev_level[2] = lvl_jit_reg;
    assign ev_high[0]  = 16'(loss_high_reg);
    assign ev_high[1]  = lat_high_reg;
    assign ev_high[2]  = jit_high_reg;
    assign ev_low[0]   = 16'(loss_low_reg);
    assign ev_low[1]   = lat_low_reg;
    assign ev_low[2]   = jit_low_reg;
    assign ev_valid    = {jit_cnt_reg != '0, lat_cnt_reg != '0, loss_cnt_reg != '0};

    always_comb
    begin
        flags_next   = flags_reg;
        raised_next  = '0;
        cleared_next = '0;
        for (int i = 0; i < NUM_ALARM; i++)
        begin
            elapsed[i] = now_reg - raise_time_reg[i];
            if (window_full_reg && ev_valid[i] && (ev_high[i] != '0))
            begin
                if (ev_level[i] >= ev_high[i])
                begin
                    if (!flags_reg[i])
                    begin
                        flags_next[i]  = 1'b1;
                        raised_next[i] = 1'b1;
                    end
                end
                else if (flags_reg[i] && (ev_level[i] < ev_low[i]) &&
                         (elapsed[i] > TIME_W'(inertia_reg)))
                begin
                    flags_next[i]   = 1'b0;
                    cleared_next[i] = 1'b1;
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg      <= SPAN_WIDTH'(SPAN_RST);
            loss_high_reg <= LEVEL_W'(LOSS_HIGH_RST);
            loss_low_reg  <= LEVEL_W'(LOSS_LOW_RST);
            lat_high_reg  <= THRESH_W'(LATENCY_HIGH_RST);
            lat_low_reg   <= THRESH_W'(LATENCY_LOW_RST);
            jit_high_reg  <= THRESH_W'(JITTER_HIGH_RST);
            jit_low_reg   <= THRESH_W'(JITTER_LOW_RST);
            inertia_reg   <= THRESH_W'(INERTIA_RST);
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_SPAN:         span_reg      <= pwdata[SPAN_WIDTH-1:0];
                REG_LOSS_HIGH:    loss_high_reg <= pwdata[LEVEL_W-1:0];
                REG_LOSS_LOW:     loss_low_reg  <= pwdata[LEVEL_W-1:0];
                REG_LATENCY_HIGH: lat_high_reg  <= pwdata[THRESH_W-1:0];
                REG_LATENCY_LOW:  lat_low_reg   <= pwdata[THRESH_W-1:0];
                REG_JITTER_HIGH:  jit_high_reg  <= pwdata[THRESH_W-1:0];
                REG_JITTER_LOW:   jit_low_reg   <= pwdata[THRESH_W-1:0];
                REG_INERTIA:      inertia_reg   <= pwdata[THRESH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer, window state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_DEC_LAT;
            loss_sum_reg    <= '0;
            lat_sum_reg     <= '0;
            jit_sum_reg     <= '0;
            loss_cnt_reg    <= '0;
            lat_cnt_reg     <= '0;
            jit_cnt_reg     <= '0;
            last_rtt_reg    <= '0;
            window_full_reg <= 1'b0;
            flags_reg       <= '0;
            for (int i = 0; i < NUM_ALARM; i++)
                raise_time_reg[i] <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_fire)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg      <= now_seconds;
                        loss_cnt_reg <= loss_cnt_inc;
                        if (loss_cnt_inc > CW'(span_reg))
                            window_full_reg <= 1'b1;
                        if (round_trip_ms == '0)
                        begin
                            loss_sum_reg <= loss_sum_reg + (LSW'(1) << FRACTION_BITS);
                        end
                        else
                        begin
                            last_rtt_reg <= round_trip_ms;
                            lat_sum_reg  <= lat_sum_reg + (SW'(round_trip_ms) << FRACTION_BITS);
                            lat_cnt_reg  <= lat_cnt_reg + CW'(1);
                            jit_sum_reg  <= jit_sum_reg + (SW'(diff) << FRACTION_BITS);
                            jit_cnt_reg  <= jit_cnt_reg + CW'(1);
                        end
                        op_reg    <= OP_DEC_LAT;
                        state_reg <= S_SETUP;
                    end
                end

                S_SETUP:
                begin
                    if (op_go)
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= op_dividend;
                        div_reg   <= op_divisor;
                        cnt_reg   <= KW'(DW - 1);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        // Skipped operation: a level with no samples reads zero.
                        if (op_reg == OP_LVL_LOSS)
                            lvl_loss_reg <= '0;
                        if (op_reg == OP_LVL_LAT)
                            lvl_lat_reg <= '0;
                        if (op_reg == OP_LVL_JIT)
                            lvl_jit_reg <= '0;
                        if (op_reg == OP_LVL_JIT)
                            state_reg <= S_EVAL;
                        else
                            op_reg <= op_t'(op_reg + 3'd1);
                    end
                end

                S_DIV:
                begin
                    rem_reg <= trial_ok ? (trial - {1'b0, div_reg}) : trial;
                    quo_reg <= {quo_reg[DW-2:0], trial_ok};
                    cnt_reg <= cnt_reg - KW'(1);
                    if (cnt_reg == '0)
                        state_reg <= S_APPLY;
                end

                S_APPLY:
                begin
                    case (op_reg)
                        OP_DEC_LAT:
                        begin
                            lat_sum_reg <= lat_sum_reg - SW'(quo_reg);
                            lat_cnt_reg <= lat_cnt_reg - CW'(1);
                        end
                        OP_DEC_LOSS:
                        begin
                            loss_sum_reg <= loss_sum_reg - LSW'(quo_reg);
                            loss_cnt_reg <= loss_cnt_reg - CW'(1);
                        end
                        OP_DEC_JIT:
                        begin
                            jit_sum_reg <= jit_sum_reg - SW'(quo_reg);
                            jit_cnt_reg <= jit_cnt_reg - CW'(1);
                        end
                        OP_LVL_LOSS: lvl_loss_reg <= quo_reg[LEVEL_W-1:0];
                        OP_LVL_LAT:  lvl_lat_reg  <= quo_reg[15:0];
                        OP_LVL_JIT:  lvl_jit_reg  <= quo_reg[15:0];
                        default:     ;
                    endcase
                    if (op_reg == OP_LVL_JIT)
                        state_reg <= S_EVAL;
                    else
                    begin
                        op_reg    <= op_t'(op_reg + 3'd1);
                        state_reg <= S_SETUP;
                    end
                end

                S_EVAL:
                begin
                    // Wait until the output register is free.
                    if (out_fire)
                    begin
                        flags_reg <= flags_next;
                        for (int i = 0; i < NUM_ALARM; i++)
                            if (raised_next[i])
                                raise_time_reg[i] <= now_reg;
                        out_flags_reg   <= flags_next;
                        out_raised_reg  <= raised_next;
                        out_cleared_reg <= cleared_next;
                        out_oper_reg    <= window_full_reg;
                        out_loss_reg    <= lvl_loss_reg;
                        out_lat_reg     <= lvl_lat_reg;
                        out_jit_reg     <= lvl_jit_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign loss_alarm      = out_flags_reg[0];
    assign latency_alarm   = out_flags_reg[1];
    assign jitter_alarm    = out_flags_reg[2];
    assign raised_mask     = out_raised_reg;
    assign cleared_mask    = out_cleared_reg;
    assign is_operational  = out_oper_reg;
    assign loss_level      = out_loss_reg;
    assign latency_average = out_lat_reg;
    assign jitter_average  = out_jit_reg;

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link quality alarm monitor.
// ----------------------------------------------------------------------------
// Probe words are sent with random gaps while the result channel is stalled
// at random. A cycle-free predictor tracks the windowed sums, decay, levels
// and alarm hysteresis. Each accepted result word is compared field by field
// with the oldest predicted report. Directed tests cover the corner cases.
// Random phases then run mostly short windows under varied thresholds and timing.
// ----------------------------------------------------------------------------
module tb_top;

    import lqam_pkg::*;

    // Predicted content of one result word.
    typedef struct packed {
        bit        loss_alarm;
        bit        latency_alarm;
        bit        jitter_alarm;
        bit [2:0]  raised_mask;
        bit [2:0]  cleared_mask;
        bit        is_operational;
        bit [13:0] loss_level;
        bit [15:0] latency_average;
        bit [15:0] jitter_average;
    } probe_report_t;

    localparam int REG_BITS [8] = '{12, 14, 14, 16, 16, 16, 16, 16};
    localparam int REG_RESET [8] = '{SPAN_RST, LOSS_HIGH_RST, LOSS_LOW_RST,
        LATENCY_HIGH_RST, LATENCY_LOW_RST, JITTER_HIGH_RST, JITTER_LOW_RST,
        INERTIA_RST};
    localparam int ONE_FIX = 1 << FRACTION_BITS_DEF;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [15:0]       round_trip_ms = '0;
    logic [31:0]       now_seconds = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              loss_alarm;
    logic              latency_alarm;
    logic              jitter_alarm;
    logic [2:0]        raised_mask;
    logic [2:0]        cleared_mask;
    logic              is_operational;
    logic [13:0]       loss_level;
    logic [15:0]       latency_average;
    logic [15:0]       jitter_average;

    // Predictor state.
    bit [15:0]       cfg [8];
    longint unsigned loss_sum, lat_sum, jit_sum;
    longint unsigned loss_cnt, lat_cnt, jit_cnt;
    bit [15:0]       last_rtt;
    bit              window_full;
    bit [2:0]        alarm_on;
    bit [31:0]       raise_stamp [3];

    probe_report_t   pending_reports [$];
    int              error_count = 0;
    bit              gaps_on = 1'b1;
    bit              stalls_on = 1'b1;
    bit [31:0]       clock_now = 0;

    link_quality_alarm_monitor i_dut (.*);

    // Clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Random back-pressure on the result channel.
    always @(posedge clk)
    begin
        out_stall <= stalls_on && ($urandom_range(99) < 32);
    end

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Reset the predictor to its power-up state.
    task automatic reset_model();
        for (int i = 0; i < 8; i++)
            cfg[i] = 16'(REG_RESET[i]);
        loss_sum = 0; lat_sum = 0; jit_sum = 0;
        loss_cnt = 0; lat_cnt = 0; jit_cnt = 0;
        last_rtt = 0;
        window_full = 0;
        alarm_on = 0;
        for (int i = 0; i < 3; i++)
            raise_stamp[i] = 0;
    endtask

    // Advance the windowed sums by one probe and return the report it causes.
    task automatic predict_report(input bit [15:0] rtt, input bit [31:0] t,
                                  output probe_report_t rep);
        longint unsigned span;
        longint unsigned diff;
        longint unsigned lvl [3];
        longint unsigned hi [3];
        longint unsigned lo [3];
        bit              cnt_ok [3];
        bit [31:0]       elapsed;
        span = cfg[REG_SPAN];
        diff = 0;
        rep = '0;
        if (rtt == 0)
        begin
            loss_sum += ONE_FIX;
            loss_cnt++;
        end
        else
        begin
            if (last_rtt != 0)
                diff = (last_rtt > rtt) ? last_rtt - rtt : rtt - last_rtt;
            last_rtt = rtt;
            loss_cnt++;
            lat_sum += longint'(rtt) << FRACTION_BITS_DEF;
            lat_cnt++;
            jit_sum += diff << FRACTION_BITS_DEF;
            jit_cnt++;
        end
        // Decay each window once its count passes the span.
        if (lat_cnt > span)
        begin
            lat_sum -= lat_sum / lat_cnt;
            lat_cnt--;
        end
        if (loss_cnt > span)
        begin
            window_full = 1;
            loss_sum -= loss_sum / loss_cnt;
            loss_cnt--;
        end
        if (jit_cnt > span)
        begin
            jit_sum -= jit_sum / jit_cnt;
            jit_cnt--;
        end
        lvl[0] = loss_cnt ? (loss_sum * LOSS_SCALE) / (loss_cnt << FRACTION_BITS_DEF) : 0;
        lvl[1] = lat_cnt ? lat_sum / (lat_cnt << FRACTION_BITS_DEF) : 0;
        lvl[2] = jit_cnt ? jit_sum / (jit_cnt << FRACTION_BITS_DEF) : 0;
        cnt_ok[0] = loss_cnt != 0;
        cnt_ok[1] = lat_cnt != 0;
        cnt_ok[2] = jit_cnt != 0;
        hi[0] = cfg[REG_LOSS_HIGH];    lo[0] = cfg[REG_LOSS_LOW];
        hi[1] = cfg[REG_LATENCY_HIGH]; lo[1] = cfg[REG_LATENCY_LOW];
        hi[2] = cfg[REG_JITTER_HIGH];  lo[2] = cfg[REG_JITTER_LOW];
        // Hysteretic alarms, evaluated only once the window has filled.
        if (window_full)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (hi[a] != 0 && cnt_ok[a])
                begin
                    elapsed = t - raise_stamp[a];
                    if (lvl[a] >= hi[a])
                    begin
                        if (!alarm_on[a])
                        begin
                            alarm_on[a] = 1;
                            raise_stamp[a] = t;
                            rep.raised_mask[a] = 1;
                        end
                    end
                    else if (alarm_on[a] && lvl[a] < lo[a] && elapsed > cfg[REG_INERTIA])
                    begin
                        alarm_on[a] = 0;
                        rep.cleared_mask[a] = 1;
                    end
                end
            end
        end
        rep.loss_alarm = alarm_on[0];
        rep.latency_alarm = alarm_on[1];
        rep.jitter_alarm = alarm_on[2];
        rep.is_operational = window_full;
        rep.loss_level = lvl[0][13:0];
        rep.latency_average = lvl[1][15:0];
        rep.jitter_average = lvl[2][15:0];
    endtask

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        probe_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = pending_reports.pop_front();
                if (loss_alarm !== want.loss_alarm)
                    report_mismatch("loss_alarm", loss_alarm, want.loss_alarm);
                if (latency_alarm !== want.latency_alarm)
                    report_mismatch("latency_alarm", latency_alarm, want.latency_alarm);
                if (jitter_alarm !== want.jitter_alarm)
                    report_mismatch("jitter_alarm", jitter_alarm, want.jitter_alarm);
                if (raised_mask !== want.raised_mask)
                    report_mismatch("raised_mask", raised_mask, want.raised_mask);
                if (cleared_mask !== want.cleared_mask)
                    report_mismatch("cleared_mask", cleared_mask, want.cleared_mask);
                if (is_operational !== want.is_operational)
                    report_mismatch("is_operational", is_operational, want.is_operational);
                if (loss_level !== want.loss_level)
                    report_mismatch("loss_level", loss_level, want.loss_level);
                if (latency_average !== want.latency_average)
                    report_mismatch("latency_average", latency_average,
                                    want.latency_average);
                if (jitter_average !== want.jitter_average)
                    report_mismatch("jitter_average", jitter_average, want.jitter_average);
            end
        end
    end

    // Send one probe word; called and returning just after a rising edge.
    task automatic send_probe(input bit [15:0] rtt, input bit [31:0] t);
        probe_report_t rep;
        in_valid <= 1'b1;
        round_trip_ms <= rtt;
        now_seconds <= t;
        do
            @(posedge clk);
        while (in_stall);
        predict_report(rtt, t, rep);
        pending_reports.push_back(rep);
        if (gaps_on && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register through the configuration port while idle.
    task automatic write_reg(input logic [2:0] idx, input bit [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg[idx] = 16'(value & ((32'd1 << REG_BITS[idx]) - 1));
        @(posedge clk);
    endtask

    // Default settings: lost probes, first good probe and RTT extremes.
    task automatic test_first_probes();
        send_probe(16'd0, 32'd0);
        send_probe(16'd1, 32'd1);
        send_probe(16'hFFFF, 32'd2);
        send_probe(16'd1, 32'd3);
        send_probe(16'd0, 32'd4);
        drain();
    endtask

    // Span zero empties every window, so levels read zero and are skipped.
    task automatic test_span_zero();
        write_reg(REG_SPAN, 32'd0);
        write_reg(REG_JITTER_HIGH, 32'd1);
        send_probe(16'd0, 32'd10);
        send_probe(16'd100, 32'd11);
        send_probe(16'd0, 32'd12);
        drain();
    endtask

    // Raising at time zero, high threshold below low, zero inertia.
    task automatic test_alarm_edges();
        write_reg(REG_SPAN, 32'd1);
        write_reg(REG_LOSS_HIGH, 32'd1);
        write_reg(REG_LOSS_LOW, 32'd10000);
        write_reg(REG_LATENCY_HIGH, 32'd5);
        write_reg(REG_LATENCY_LOW, 32'd10);
        write_reg(REG_JITTER_LOW, 32'd2);
        write_reg(REG_INERTIA, 32'd0);
        send_probe(16'd0, 32'd0);
        send_probe(16'd50, 32'd0);
        send_probe(16'd3, 32'd0);
        send_probe(16'd3, 32'd1);
        send_probe(16'd3, 32'd2);
        drain();
    endtask

    // Elapsed time across the wrap of the seconds counter.
    task automatic test_time_wrap();
        write_reg(REG_LATENCY_HIGH, 32'd100);
        write_reg(REG_LATENCY_LOW, 32'd50);
        write_reg(REG_INERTIA, 32'd5);
        send_probe(16'd300, 32'hFFFF_FFFE);
        send_probe(16'd10, 32'd2);
        send_probe(16'd10, 32'd3);
        send_probe(16'd10, 32'd4);
        drain();
    endtask

    // Largest span and extreme register values, some written wider than their fields.
    task automatic test_register_extremes();
        write_reg(REG_SPAN, 32'hFFFF_FFFF);
        write_reg(REG_LOSS_HIGH, 32'd10000);
        write_reg(REG_LOSS_LOW, 32'hFFFF_C000);
        write_reg(REG_LATENCY_HIGH, 32'hFFFF_FFFF);
        write_reg(REG_LATENCY_LOW, 32'd65535);
        write_reg(REG_JITTER_HIGH, 32'd65535);
        write_reg(REG_JITTER_LOW, 32'hABCD_0000);
        write_reg(REG_INERTIA, 32'd65535);
        send_probe(16'h5555, 32'h5555_5555);
        send_probe(16'hAAAA, 32'hAAAA_AAAA);
        send_probe(16'd0, 32'hFFFF_FFFF);
        drain();
    endtask

    // Pick a random threshold pair for one alarm.
    task automatic random_thresholds(input logic [2:0] hi_idx, input logic [2:0] lo_idx,
                                     input int top);
        int h;
        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, top);
        write_reg(hi_idx, h);
        write_reg(lo_idx, ($urandom_range(7) == 0) ? $urandom_range(0, top)
                                                  : $urandom_range(0, h));
    endtask

    // Random phases: mostly short windows, varied thresholds, clustered RTTs.
    task automatic test_random_traffic();
        int span_pick;
        int centre;
        int spread;
        int loss_pct;
        int count;
        bit [15:0] rtt;
        for (int phase = 0; phase < 14; phase++)
        begin
            span_pick = (phase == 6) ? 4095 : (phase == 9) ? 0 : $urandom_range(1, 12);
            write_reg(REG_SPAN, span_pick);
            random_thresholds(REG_LOSS_HIGH, REG_LOSS_LOW, 10000);
            centre = $urandom_range(1, 400);
            spread = $urandom_range(0, 200);
            random_thresholds(REG_LATENCY_HIGH, REG_LATENCY_LOW, centre + spread);
            random_thresholds(REG_JITTER_HIGH, REG_JITTER_LOW, spread + 1);
            write_reg(REG_INERTIA, (phase == 2) ? 65535 : $urandom_range(0, 12));
            loss_pct = $urandom_range(0, 40);
            if (phase == 4)
                clock_now = 32'hFFFF_FFC0;
            gaps_on = !(phase == 3 || phase == 5);
            stalls_on = !(phase == 3 || phase == 5);
            count = (span_pick == 4095) ? 20 : 95;
            for (int n = 0; n < count; n++)
            begin
                if ($urandom_range(99) < loss_pct)
                    rtt = 0;
                else if ($urandom_range(99) < 3)
                    rtt = 16'($urandom_range(0, 65535));
                else
                    rtt = 16'($urandom_range((centre > spread) ? centre - spread : 1,
                                             centre + spread));
                if ($urandom_range(99) < 2)
                    clock_now = $urandom;
                else
                    clock_now += $urandom_range(0, 4);
                send_probe(rtt, clock_now);
                // Hold off until the block has answered everything.
                if (phase == 7 && n % 20 == 19)
                    drain();
            end
            drain();
        end
        gaps_on = 1;
        stalls_on = 1;
    endtask

    initial
    begin
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_probes();
        test_span_zero();
        test_alarm_edges();
        test_time_wrap();
        test_register_extremes();
        test_random_traffic();
        drain();
        repeat (300) @(posedge clk);
        if (pending_reports.size() != 0)
            report_mismatch("words never returned", 0, pending_reports.size());
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #80_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
